### src/tlak_pkg.sv
`timescale 1ns / 1ps
package tlak_pkg;
   localparam int ANGLE_BITS = 16;
   localparam int TRIG_STAGES = 16;
   localparam int NSTG = (TRIG_STAGES < 24) ? TRIG_STAGES : 24;
   localparam int LEN_W = 16;
   localparam int OUT_W = 18;
   localparam int CW = 34;
   localparam int ZW = 33;
   localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
   localparam logic [0:0] REG_LINK_ONE = 1'b0;
   localparam logic [0:0] REG_LINK_TWO = 1'b1;

   typedef logic [23:0][31:0] atan_arr_type;
   localparam atan_arr_type ATAN = '{
      32'd81, 32'd163, 32'd326, 32'd652, 32'd1304, 32'd2608, 32'd5215, 32'd10430,
      32'd20861, 32'd41722, 32'd83443, 32'd166886, 32'd333772, 32'd667544,
      32'd1335087, 32'd2670163, 32'd5340245, 32'd10679838, 32'd21354465,
      32'd42667331, 32'd85004756, 32'd167458907, 32'd316933406, 32'd536870912};

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
      logic [1:0] q;
   } rot_type;

   function automatic logic signed [16:0] to_q15(input logic signed [CW-1:0] v);
      logic signed [CW-1:0] r;
      r = (v + CW'(16384)) >>> 15;
      if (r > CW'(32767)) r = CW'(32767);
      if (r < CW'(-32767)) r = CW'(-32767);
      return r[16:0];
   endfunction
endpackage

### src/tlak_if.sv
`timescale 1ns / 1ps
interface tlak_req_if;
   logic valid;
   logic ready;
   logic [tlak_pkg::ANGLE_BITS-1:0] joint_one_angle;
   logic [tlak_pkg::ANGLE_BITS-1:0] joint_two_angle;
   modport source(output valid, joint_one_angle, joint_two_angle, input ready);
   modport sink(input valid, joint_one_angle, joint_two_angle, output ready);
endinterface

interface tlak_rsp_if;
   logic valid;
   logic ready;
   logic signed [tlak_pkg::OUT_W-1:0] tip_x;
   logic signed [tlak_pkg::OUT_W-1:0] tip_y;
   logic signed [tlak_pkg::OUT_W-1:0] jac_row0_col0;
   logic signed [tlak_pkg::OUT_W-1:0] jac_row0_col1;
   logic signed [tlak_pkg::OUT_W-1:0] jac_row1_col0;
   logic signed [tlak_pkg::OUT_W-1:0] jac_row1_col1;
   modport source(output valid, tip_x, tip_y, jac_row0_col0, jac_row0_col1,
      jac_row1_col0, jac_row1_col1, input ready);
   modport sink(input valid, tip_x, tip_y, jac_row0_col0, jac_row0_col1,
      jac_row1_col0, jac_row1_col1, output ready);
endinterface

interface tlak_csr_if;
   logic valid;
   logic ready;
   logic [0:0] index;
   logic [tlak_pkg::LEN_W-1:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

### src/two_link_arm_kinematics.sv
`timescale 1ns / 1ps
// path: cordic input reg, rotation stages, product regs, output regs
// throughput: one item per cycle, set by the fully pipelined cordic rotators
// a stall on rsp freezes the whole pipeline in place
// reset: synchronous, clears valid bits, link lengths return to 4096
module two_link_arm_kinematics (
   input logic clock,
   input logic reset,
   tlak_req_if.sink req,
   tlak_rsp_if.source rsp,
   tlak_csr_if.sink csr
);
   localparam int LAT = tlak_pkg::NSTG + 3;
   logic [LAT-1:0] vld_ff, vld_in;
   logic [tlak_pkg::LEN_W-1:0] l1_ff, l2_ff;
   logic en;
   logic [tlak_pkg::ANGLE_BITS-1:0] sum_angle;
   logic signed [16:0] c1, s1, c12, s12;
   logic signed [tlak_pkg::OUT_W-1:0] px, py, npy, nl2s, l2c;

   assign en = !vld_ff[LAT-1] || rsp.ready;
   assign req.ready = en;
   assign csr.ready = 1'b1;
   assign sum_angle = req.joint_one_angle + req.joint_two_angle;
   assign vld_in = {vld_ff[LAT-2:0], req.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         l1_ff <= 16'd4096;
         l2_ff <= 16'd4096;
      end else begin
         if (en) vld_ff <= vld_in;
         if (csr.valid) begin
            unique case (csr.index)
               tlak_pkg::REG_LINK_ONE: l1_ff <= csr.data;
               tlak_pkg::REG_LINK_TWO: l2_ff <= csr.data;
               default: ;
            endcase
         end
      end
   end

   tlak_cordic u_trig_a (.clock(clock), .en(en), .angle(req.joint_one_angle),
      .cos_out(c1), .sin_out(s1));
   tlak_cordic u_trig_s (.clock(clock), .en(en), .angle(sum_angle),
      .cos_out(c12), .sin_out(s12));

   tlak_combine u_comb (.clock(clock), .en(en), .l1(l1_ff), .l2(l2_ff),
      .c1(c1), .s1(s1), .c12(c12), .s12(s12),
      .px(px), .py(py), .npy(npy), .nl2s(nl2s), .l2c(l2c));

   assign rsp.valid = vld_ff[LAT-1];
   assign rsp.tip_x = px;
   assign rsp.tip_y = py;
   assign rsp.jac_row0_col0 = npy;
   assign rsp.jac_row0_col1 = nl2s;
   assign rsp.jac_row1_col0 = px;
   assign rsp.jac_row1_col1 = l2c;
endmodule

### src/tlak_cordic.sv
`timescale 1ns / 1ps
module tlak_cordic (
   input  logic clock,
   input  logic en,
   input  logic [tlak_pkg::ANGLE_BITS-1:0] angle,
   output logic signed [16:0] cos_out,
   output logic signed [16:0] sin_out
);
   tlak_pkg::rot_type stg_ff [tlak_pkg::NSTG+1];
   tlak_pkg::rot_type stg_in;
   logic [31:0] phase;
   logic [31:0] d;
   logic [1:0] q;
   logic signed [16:0] cr, sr;

   always_comb begin
      phase = {angle, {(32-tlak_pkg::ANGLE_BITS){1'b0}}};
      q = 2'((phase + 32'h2000_0000) >> 30);
      d = phase - {q, 30'd0};
      stg_in.x = tlak_pkg::GAIN_Q30;
      stg_in.y = '0;
      stg_in.z = tlak_pkg::ZW'(signed'(d));
      stg_in.q = q;
   end

   always_ff @(posedge clock) begin
      if (en) stg_ff[0] <= stg_in;
   end

   for (genvar i = 0; i < tlak_pkg::NSTG; i++) begin : g_stage
      tlak_pkg::rot_type s_in;
      always_comb begin
         s_in.q = stg_ff[i].q;
         if (!stg_ff[i].z[tlak_pkg::ZW-1]) begin
            s_in.x = stg_ff[i].x - (stg_ff[i].y >>> i);
            s_in.y = stg_ff[i].y + (stg_ff[i].x >>> i);
            s_in.z = stg_ff[i].z - tlak_pkg::ZW'(tlak_pkg::ATAN[i]);
         end else begin
            s_in.x = stg_ff[i].x + (stg_ff[i].y >>> i);
            s_in.y = stg_ff[i].y - (stg_ff[i].x >>> i);
            s_in.z = stg_ff[i].z + tlak_pkg::ZW'(tlak_pkg::ATAN[i]);
         end
      end
      always_ff @(posedge clock) begin
         if (en) stg_ff[i+1] <= s_in;
      end
   end

   always_comb begin
      cr = tlak_pkg::to_q15(stg_ff[tlak_pkg::NSTG].x);
      sr = tlak_pkg::to_q15(stg_ff[tlak_pkg::NSTG].y);
      case (stg_ff[tlak_pkg::NSTG].q)
         2'd0: begin cos_out = cr; sin_out = sr; end
         2'd1: begin cos_out = -sr; sin_out = cr; end
         2'd2: begin cos_out = -cr; sin_out = -sr; end
         default: begin cos_out = sr; sin_out = -cr; end
      endcase
   end
endmodule

### src/tlak_combine.sv
`timescale 1ns / 1ps
module tlak_combine (
   input  logic clock,
   input  logic en,
   input  logic [tlak_pkg::LEN_W-1:0] l1,
   input  logic [tlak_pkg::LEN_W-1:0] l2,
   input  logic signed [16:0] c1,
   input  logic signed [16:0] s1,
   input  logic signed [16:0] c12,
   input  logic signed [16:0] s12,
   output logic signed [tlak_pkg::OUT_W-1:0] px,
   output logic signed [tlak_pkg::OUT_W-1:0] py,
   output logic signed [tlak_pkg::OUT_W-1:0] npy,
   output logic signed [tlak_pkg::OUT_W-1:0] nl2s,
   output logic signed [tlak_pkg::OUT_W-1:0] l2c
);
   logic signed [34:0] p1c_ff, p1s_ff, p2c_ff, p2s_ff;
   logic signed [35:0] sx, sy;
   logic signed [35:0] ox_in, oy_in, onpy_in, onl2s_in, ol2c_in;
   logic signed [tlak_pkg::OUT_W-1:0] px_ff, py_ff, npy_ff, nl2s_ff, l2c_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p1c_ff <= 35'(signed'({1'b0, l1})) * 35'(c1);
         p1s_ff <= 35'(signed'({1'b0, l1})) * 35'(s1);
         p2c_ff <= 35'(signed'({1'b0, l2})) * 35'(c12);
         p2s_ff <= 35'(signed'({1'b0, l2})) * 35'(s12);
      end
   end

   always_comb begin
      sx = 36'(p1c_ff) + 36'(p2c_ff);
      sy = 36'(p1s_ff) + 36'(p2s_ff);
      ox_in = (sx + 36'sd16384) >>> 15;
      oy_in = (sy + 36'sd16384) >>> 15;
      onpy_in = (36'sd16384 - sy) >>> 15;
      onl2s_in = (36'sd16384 - 36'(p2s_ff)) >>> 15;
      ol2c_in = (36'(p2c_ff) + 36'sd16384) >>> 15;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= ox_in[tlak_pkg::OUT_W-1:0];
         py_ff <= oy_in[tlak_pkg::OUT_W-1:0];
         npy_ff <= onpy_in[tlak_pkg::OUT_W-1:0];
         nl2s_ff <= onl2s_in[tlak_pkg::OUT_W-1:0];
         l2c_ff <= ol2c_in[tlak_pkg::OUT_W-1:0];
      end
   end

   assign px = px_ff;
   assign py = py_ff;
   assign npy = npy_ff;
   assign nl2s = nl2s_ff;
   assign l2c = l2c_ff;
endmodule

### src/tlak_checker.sv
`timescale 1ns / 1ps
module tlak_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic signed [tlak_pkg::OUT_W-1:0] tip_x,
   input logic signed [tlak_pkg::OUT_W-1:0] jac_row1_col0
);
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(tip_x)) else $error("rsp dropped");
   a_x_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> tip_x == jac_row1_col0) else $error("x mismatch");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready) else $error("stalled without output");
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("valid after reset");
endmodule

bind two_link_arm_kinematics tlak_checker u_chk (.clock(clock), .reset(reset),
   .req_ready(req.ready), .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready), .tip_x(rsp.tip_x), .jac_row1_col0(rsp.jac_row1_col0));

### tb/two_link_arm_kinematics_tb.sv
`timescale 1ns / 1ps
module two_link_arm_kinematics_tb;

   typedef struct packed {
      logic signed [tlak_pkg::OUT_W-1:0] tip_x;
      logic signed [tlak_pkg::OUT_W-1:0] tip_y;
      logic signed [tlak_pkg::OUT_W-1:0] j00;
      logic signed [tlak_pkg::OUT_W-1:0] j01;
      logic signed [tlak_pkg::OUT_W-1:0] j10;
      logic signed [tlak_pkg::OUT_W-1:0] j11;
   } pose_type;

   localparam int LATENCY = tlak_pkg::NSTG + 3;
   localparam longint CYCLE_LIMIT = 400000;

   logic clock;
   logic reset;
   tlak_req_if req ();
   tlak_rsp_if rsp ();
   tlak_csr_if csr ();

   two_link_arm_kinematics dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   pose_type pose_queue[$];
   longint unsigned link_one_len;
   longint unsigned link_two_len;
   int errors;
   longint cycles;
   int send_idle_pct;
   int recv_stall_pct;

   // atan(2^-i) in 2^32 phase units
   longint arctan_lut[24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838, 5340245,
      2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
      10430, 5215, 2608, 1304, 652, 326, 163, 81};

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint q15_clamp(longint v);
      longint r;
      r = floor_shift(v + 16384, 15);
      if (r > 32767) r = 32767;
      if (r < -32767) r = -32767;
      return r;
   endfunction

   task automatic sin_cos(input logic [tlak_pkg::ANGLE_BITS-1:0] ang, output longint c,
                          output longint s);
      logic [31:0] phase;
      logic [1:0] quad;
      logic [31:0] resid;
      longint z, x, y, dx, dy, cr, sr;
      phase = {ang, {(32 - tlak_pkg::ANGLE_BITS){1'b0}}};
      quad = 2'((phase + 32'h2000_0000) >> 30);
      resid = phase - {quad, 30'b0};
      z = longint'(signed'(resid));
      x = 652032874;
      y = 0;
      for (int i = 0; i < tlak_pkg::NSTG; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= arctan_lut[i];
         end else begin
            x += dx; y -= dy; z += arctan_lut[i];
         end
      end
      cr = q15_clamp(x);
      sr = q15_clamp(y);
      case (quad)
         2'd0: begin c = cr; s = sr; end
         2'd1: begin c = -sr; s = cr; end
         2'd2: begin c = -cr; s = -sr; end
         default: begin c = sr; s = -cr; end
      endcase
   endtask

   function automatic logic [tlak_pkg::OUT_W-1:0] to_out_units(longint sum);
      return tlak_pkg::OUT_W'(floor_shift(sum + 16384, 15));
   endfunction

   task automatic predict_pose(input logic [tlak_pkg::ANGLE_BITS-1:0] a,
                               input logic [tlak_pkg::ANGLE_BITS-1:0] b);
      longint c1, s1, c12, s12, px, py, l1, l2;
      pose_type p;
      l1 = longint'(link_one_len);
      l2 = longint'(link_two_len);
      sin_cos(a, c1, s1);
      sin_cos(tlak_pkg::ANGLE_BITS'(a + b), c12, s12);
      px = l1 * c1 + l2 * c12;
      py = l1 * s1 + l2 * s12;
      p.tip_x = to_out_units(px);
      p.tip_y = to_out_units(py);
      p.j00 = to_out_units(-py);
      p.j01 = to_out_units(-(l2 * s12));
      p.j10 = to_out_units(px);
      p.j11 = to_out_units(l2 * c12);
      pose_queue.push_back(p);
   endtask

   // valid stays high after a transfer so items can follow back to back
   task automatic send_angles(input logic [tlak_pkg::ANGLE_BITS-1:0] a,
                              input logic [tlak_pkg::ANGLE_BITS-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.joint_one_angle <= a;
      req.joint_two_angle <= b;
      predict_pose(a, b);
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   task automatic write_link(input logic [0:0] idx, input logic [tlak_pkg::LEN_W-1:0] len);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= len;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      if (idx == tlak_pkg::REG_LINK_ONE) link_one_len = len;
      else link_two_len = len;
   endtask

   task automatic drain_pipeline();
      req.valid <= 1'b0;
      while (pose_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic set_links(input logic [tlak_pkg::LEN_W-1:0] l1,
                            input logic [tlak_pkg::LEN_W-1:0] l2);
      drain_pipeline();
      write_link(tlak_pkg::REG_LINK_ONE, l1);
      write_link(tlak_pkg::REG_LINK_TWO, l2);
      csr.valid <= 1'b0;
   endtask

   // rsp side: random stall and per-field compare
   always @(posedge clock) begin
      pose_type e;
      if (!reset) begin
         if (rsp.valid && rsp.ready) begin
            if (pose_queue.size() == 0) begin
               $error("unexpected rsp transfer");
               errors++;
            end else begin
               e = pose_queue.pop_front();
               if (rsp.tip_x !== e.tip_x) begin
                  $error("tip_x exp %0d got %0d", e.tip_x, rsp.tip_x); errors++;
               end
               if (rsp.tip_y !== e.tip_y) begin
                  $error("tip_y exp %0d got %0d", e.tip_y, rsp.tip_y); errors++;
               end
               if (rsp.jac_row0_col0 !== e.j00) begin
                  $error("jac_row0_col0 exp %0d got %0d", e.j00, rsp.jac_row0_col0); errors++;
               end
               if (rsp.jac_row0_col1 !== e.j01) begin
                  $error("jac_row0_col1 exp %0d got %0d", e.j01, rsp.jac_row0_col1); errors++;
               end
               if (rsp.jac_row1_col0 !== e.j10) begin
                  $error("jac_row1_col0 exp %0d got %0d", e.j10, rsp.jac_row1_col0); errors++;
               end
               if (rsp.jac_row1_col1 !== e.j11) begin
                  $error("jac_row1_col1 exp %0d got %0d", e.j11, rsp.jac_row1_col1); errors++;
               end
            end
         end
         rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic test_directed_angles();
      logic [tlak_pkg::ANGLE_BITS-1:0] corners[8] = '{16'h0000, 16'h0001, 16'h3FFF,
         16'h4000, 16'h8000, 16'hC000, 16'hE000, 16'hFFFF};
      foreach (corners[i]) send_angles(corners[i], corners[7 - i]);
      send_angles(16'hFFFF, 16'hFFFF);
      send_angles(16'h2000, 16'h2000);
      send_angles(16'h1234, 16'hEDCC);
      send_angles(16'h5555, 16'hAAAA);
   endtask

   task automatic test_link_extremes();
      set_links(16'hFFFF, 16'hFFFF);
      test_directed_angles();
      set_links(16'h0000, 16'h0000);
      test_directed_angles();
      set_links(16'h0000, 16'hFFFF);
      send_angles(16'h1000, 16'h7000);
      send_angles(16'hA5A5, 16'h5A5A);
   endtask

   task automatic test_random_poses(input int n);
      for (int i = 0; i < n; i++) begin
         if (i % 100 == 0)
            set_links(tlak_pkg::LEN_W'($urandom()), tlak_pkg::LEN_W'($urandom()));
         send_angles(tlak_pkg::ANGLE_BITS'($urandom()), tlak_pkg::ANGLE_BITS'($urandom()));
      end
   endtask

   initial begin
      reset = 1'b1;
      errors = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      req.valid = 1'b0;
      req.joint_one_angle = '0;
      req.joint_two_angle = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0;
      csr.index = '0;
      csr.data = '0;
      link_one_len = 4096;
      link_two_len = 4096;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_angles();
      test_link_extremes();
      set_links(16'd4096, 16'd4096);
      test_random_poses(400);
      send_idle_pct = 53;
      test_random_poses(400);
      send_idle_pct = 0;
      recv_stall_pct = 53;
      test_random_poses(400);
      send_idle_pct = 37;
      recv_stall_pct = 37;
      test_random_poses(450);

      drain_pipeline();
      if (errors == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end
endmodule
